// ----- design/assert_macros.svh -----
// assertion helpers included by hough_line_pair_intersect
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked property, also active during reset
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/hlpi_pkg.sv -----
// ---------------------------------------------------------------------------
// hlpi_pkg
// Shared types and constants of the Hough line pair intersection block.
// ---------------------------------------------------------------------------
package hlpi_pkg;

    localparam logic [15:0] MIN_ANGLE_RESET = 16'd2048;
    localparam logic [31:0] ONE_Q30         = 32'h4000_0000;
    localparam logic [64:0] HALF_Q30        = 65'h0_2000_0000;
    localparam int          NUM_CELLS       = 33;
    localparam int          NUM_STAGES      = 43;

    // quarter wave taylor coefficients, q30, alternating sign
    localparam logic [31:0] TAYLOR_Q30 [0:4] = '{
        32'd1686629713, 32'd693598668, 32'd85569306, 32'd5026995, 32'd172273
    };

    // one restoring division step state
    typedef struct packed {
        logic [31:0] r;
        logic [32:0] n;
        logic [32:0] q;
        logic [31:0] d;
    } div_cell_t;

    typedef struct packed {
        logic acc;
        logic neg_x;
        logic neg_y;
        logic ovf_x;
        logic ovf_y;
        logic dz;
    } side_t;

    // (a*b + 2^29) >> 30
    function automatic logic [33:0] rnd_mul(input logic [31:0] a, input logic [31:0] b);
        logic [64:0] pr;
        pr = 65'(a) * 65'(b) + HALF_Q30;
        return pr[63:30];
    endfunction

endpackage

// ----- design/hlpi_sine.sv -----
// ---------------------------------------------------------------------------
// hlpi_sine
// Six stage q30 sine of an angle in units of pi/65536, one multiply a stage.
// ---------------------------------------------------------------------------
module hlpi_sine import hlpi_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic [16:0]        ang,
    output logic signed [31:0] sin_q30
);

    logic [15:0] v;
    logic [16:0] k;
    logic [29:0] z;
    logic [33:0] z2_full;
    logic [33:0] s_full;
    logic [31:0] mag;

    logic [29:0] z_reg    [0:4];
    logic [30:0] z2_reg   [0:4];
    logic        one_reg  [0:4];
    logic        neg_reg  [0:4];
    logic [31:0] p_reg    [0:3];
    logic signed [31:0] sin_reg;

    // fold to the first quarter wave
    always_comb begin
        v = ang[15:0];
        k = v[15] ? (17'd65536 - {1'b0, v}) : {1'b0, v};
        z = {k[14:0], 15'd0};
        z2_full = rnd_mul({2'b00, z}, {2'b00, z});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z_reg[0]   <= z;
            z2_reg[0]  <= z2_full[30:0];
            one_reg[0] <= k[15];
            neg_reg[0] <= ang[16];
        end
    end

    // horner steps
    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_horner
            logic [31:0] p_in;
            logic [33:0] t;
            always_comb begin
                p_in = (g == 0) ? TAYLOR_Q30[4] : p_reg[(g == 0) ? 0 : g - 1];
                t    = rnd_mul({1'b0, z2_reg[g]}, p_in);
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    p_reg[g]     <= TAYLOR_Q30[3 - g] - t[31:0];
                    z_reg[g+1]   <= z_reg[g];
                    z2_reg[g+1]  <= z2_reg[g];
                    one_reg[g+1] <= one_reg[g];
                    neg_reg[g+1] <= neg_reg[g];
                end
            end
        end
    endgenerate

    always_comb begin
        s_full = rnd_mul({2'b00, z_reg[4]}, p_reg[3]);
        if (one_reg[4] || s_full > {2'b00, ONE_Q30}) begin
            mag = ONE_Q30;
        end else begin
            mag = s_full[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg <= neg_reg[4] ? -$signed(mag) : $signed(mag);
        end
    end

    assign sin_q30 = sin_reg;

endmodule

// ----- design/hlpi_div_cell.sv -----
// ---------------------------------------------------------------------------
// hlpi_div_cell
// One restoring division cell: takes one numerator bit, yields one quotient bit.
// ---------------------------------------------------------------------------
module hlpi_div_cell import hlpi_pkg::*; (
    input  logic      aclk,
    input  logic      en,
    input  div_cell_t st_in,
    output div_cell_t st_out
);

    logic [32:0] t;
    logic        ge;
    logic [32:0] diff;
    div_cell_t   st_next;
    div_cell_t   st_reg;

    always_comb begin
        t    = {st_in.r, st_in.n[32]};
        ge   = t >= {1'b0, st_in.d};
        diff = t - {1'b0, st_in.d};
        st_next.r = ge ? diff[31:0] : t[31:0];
        st_next.n = {st_in.n[31:0], 1'b0};
        st_next.q = {st_in.q[31:0], ge};
        st_next.d = st_in.d;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg <= st_next;
        end
    end

    assign st_out = st_reg;

endmodule

// ----- design/hough_line_pair_intersect.sv -----
// One line pair enters per clock, with a new pair accepted every cycle while the output
// side keeps up; a pair passes through the input stage, the six stage sine pipes, a
// product stage, a numerator stage, the divider load stage, the 33 cell restoring
// divider chain that gives one quotient bit per cell and the output register before
// m_tvalid for its result rises. When the output stalls the whole pipe holds, but a
// pair is still taken into an empty input stage. min_angle must be written through
// cfg_wr_en/cfg_wr_data only while idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
// hough_line_pair_intersect
// Accepts or rejects a pair of polar Hough lines and gives their crossing.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hough_line_pair_intersect import hlpi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // rho_a, theta_a, rho_b, theta_b
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // cross_x, cross_y
    output logic [1:0]  m_tuser    // accepted, saturated
);

    logic [15:0]            min_angle_reg;
    logic [NUM_STAGES-1:0]  v_reg;
    logic                   m_tvalid_reg;
    logic                   adv;
    logic                   s_acc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_angle_reg <= MIN_ANGLE_RESET;
        end else if (cfg_wr_en) begin
            min_angle_reg <= cfg_wr_data;
        end
    end

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv || !v_reg[0];
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            v_reg        <= {v_reg[NUM_STAGES-2:0], s_acc};
            m_tvalid_reg <= v_reg[NUM_STAGES-1];
        end else begin
            v_reg[0] <= v_reg[0] | s_acc;
        end
    end

    // acceptance test on the incoming word
    logic [16:0] wa, wb, adiff;
    logic        acc_in;
    always_comb begin
        wa = (s_tdata[31:16] < min_angle_reg) ? {1'b1, s_tdata[31:16]} : {1'b0, s_tdata[31:16]};
        wb = (s_tdata[63:48] < min_angle_reg) ? {1'b1, s_tdata[63:48]} : {1'b0, s_tdata[63:48]};
        adiff  = (wa > wb) ? wa - wb : wb - wa;
        acc_in = adiff > {1'b0, min_angle_reg};
    end

    logic signed [15:0] ra0_reg, rb0_reg;
    logic [15:0]        ta0_reg, tb0_reg;
    logic               acc0_reg;

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            ra0_reg  <= s_tdata[15:0];
            ta0_reg  <= s_tdata[31:16];
            rb0_reg  <= s_tdata[47:32];
            tb0_reg  <= s_tdata[63:48];
            acc0_reg <= acc_in;
        end
    end

    logic signed [31:0] sa, ca, sb, cb, det;

    hlpi_sine u_sa (.aclk(aclk), .en(adv), .ang({1'b0, ta0_reg}), .sin_q30(sa));
    hlpi_sine u_ca (.aclk(aclk), .en(adv), .ang({1'b0, ta0_reg} + 17'd32768), .sin_q30(ca));
    hlpi_sine u_sb (.aclk(aclk), .en(adv), .ang({1'b0, tb0_reg}), .sin_q30(sb));
    hlpi_sine u_cb (.aclk(aclk), .en(adv), .ang({1'b0, tb0_reg} + 17'd32768), .sin_q30(cb));
    hlpi_sine u_det (.aclk(aclk), .en(adv), .ang({1'b0, tb0_reg} - {1'b0, ta0_reg}),
                     .sin_q30(det));

    // rho and acceptance follow the sine pipes
    logic signed [15:0] ra_reg  [0:5];
    logic signed [15:0] rb_reg  [0:5];
    logic               acc_reg [0:7];

    always_ff @(posedge aclk) begin
        if (adv) begin
            ra_reg[0]  <= ra0_reg;
            rb_reg[0]  <= rb0_reg;
            acc_reg[0] <= acc0_reg;
            for (int i = 1; i < 6; i++) begin
                ra_reg[i] <= ra_reg[i-1];
                rb_reg[i] <= rb_reg[i-1];
            end
            for (int i = 1; i < 8; i++) begin
                acc_reg[i] <= acc_reg[i-1];
            end
        end
    end

    // products
    logic signed [47:0] ra_w, rb_w;
    logic signed [47:0] pxa_reg, pxb_reg, pya_reg, pyb_reg;
    logic signed [31:0] det7_reg;

    assign ra_w = 48'(ra_reg[5]);
    assign rb_w = 48'(rb_reg[5]);

    always_ff @(posedge aclk) begin
        if (adv) begin
            pxa_reg  <= ra_w * 48'(sb);
            pxb_reg  <= rb_w * 48'(sa);
            pya_reg  <= rb_w * 48'(ca);
            pyb_reg  <= ra_w * 48'(cb);
            det7_reg <= det;
        end
    end

    // numerators and rounding offsets
    logic signed [52:0] numx, numy;
    logic [52:0]        absx, absy;
    logic [31:0]        dabs;
    logic [51:0]        nx_reg, ny_reg;
    logic [31:0]        d_reg;
    logic               negx_reg, negy_reg, dz_reg;

    always_comb begin
        numx = 53'(pxa_reg - pxb_reg) <<< 4;
        numy = 53'(pya_reg - pyb_reg) <<< 4;
        absx = numx[52] ? 53'(-numx) : 53'(numx);
        absy = numy[52] ? 53'(-numy) : 53'(numy);
        dabs = det7_reg[31] ? 32'(-det7_reg) : 32'(det7_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nx_reg   <= {absx[50:0], 1'b0} + 52'(dabs);
            ny_reg   <= {absy[50:0], 1'b0} + 52'(dabs);
            d_reg    <= {dabs[30:0], 1'b0};
            negx_reg <= numx[52] ^ det7_reg[31];
            negy_reg <= numy[52] ^ det7_reg[31];
            dz_reg   <= (det7_reg == 32'sd0);
        end
    end

    // divider chains
    div_cell_t cx_st [0:NUM_CELLS];
    div_cell_t cy_st [0:NUM_CELLS];
    side_t     side_reg [0:NUM_CELLS];
    div_cell_t cx_init_reg, cy_init_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            cx_init_reg <= '{r: {13'd0, nx_reg[51:33]}, n: nx_reg[32:0], q: '0, d: d_reg};
            cy_init_reg <= '{r: {13'd0, ny_reg[51:33]}, n: ny_reg[32:0], q: '0, d: d_reg};
            side_reg[0] <= '{acc: acc_reg[7], neg_x: negx_reg, neg_y: negy_reg,
                             ovf_x: ({13'd0, nx_reg[51:33]} >= d_reg),
                             ovf_y: ({13'd0, ny_reg[51:33]} >= d_reg),
                             dz: dz_reg};
            for (int i = 1; i <= NUM_CELLS; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign cx_st[0] = cx_init_reg;
    assign cy_st[0] = cy_init_reg;

    genvar c;
    generate
        for (c = 0; c < NUM_CELLS; c++) begin : g_cells
            hlpi_div_cell u_cx (.aclk(aclk), .en(adv), .st_in(cx_st[c]), .st_out(cx_st[c+1]));
            hlpi_div_cell u_cy (.aclk(aclk), .en(adv), .st_in(cy_st[c]), .st_out(cy_st[c+1]));
        end
    endgenerate

    // sign and saturation of the rounded quotient
    function automatic logic [32:0] finish(input logic [32:0] q, input logic neg,
                                           input logic ovf, input logic dz);
        logic [32:0] res;
        if (dz) begin
            res = {1'b1, 32'd0};
        end else if (neg) begin
            if (ovf || q > 33'h0_8000_0000) begin
                res = {1'b1, 32'h8000_0000};
            end else begin
                res = {1'b0, 32'(-q)};
            end
        end else begin
            if (ovf || q > 33'h0_7FFF_FFFF) begin
                res = {1'b1, 32'h7FFF_FFFF};
            end else begin
                res = {1'b0, q[31:0]};
            end
        end
        return res;
    endfunction

    side_t       sd;
    logic [32:0] rx, ry;
    logic [63:0] m_tdata_reg;
    logic [1:0]  m_tuser_reg;

    always_comb begin
        sd = side_reg[NUM_CELLS];
        rx = finish(cx_st[NUM_CELLS].q, sd.neg_x, sd.ovf_x, sd.dz);
        ry = finish(cy_st[NUM_CELLS].q, sd.neg_y, sd.ovf_y, sd.dz);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (sd.acc) begin
                m_tdata_reg <= {ry[31:0], rx[31:0]};
                m_tuser_reg <= {rx[32] | ry[32], 1'b1};
            end else begin
                m_tdata_reg <= '0;
                m_tuser_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `ASSERT_CLK(a_reject_zero, aclk, aresetn, m_tvalid && !m_tuser[0] |-> m_tdata == 64'd0 && !m_tuser[1], "rejected pair with nonzero result")
    `ASSERT_CLK(a_sat_acc, aclk, aresetn, m_tvalid && m_tuser[1] |-> m_tuser[0], "saturation flagged on rejected pair")
    `ASSERT_CLK(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(v_reg[NUM_STAGES-1]), "pipeline moved during stall")
    `ASSERT_CLK_NR(a_reset_empty, aclk, !aresetn |=> !m_tvalid && v_reg == '0, "pipeline not empty after reset")

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the Hough line pair intersection block: a table
// of directed pairs, then random pairs over several min_angle settings,
// every word compared with a stored result or a bit-exact fixed-point predictor.
// ---------------------------------------------------------------------------
module tb import hlpi_pkg::*; ();

    localparam int LIMIT        = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int PHASE_ITEMS  = 272;

    typedef struct {
        logic signed [15:0] rho_a;
        logic [15:0]        theta_a;
        logic signed [15:0] rho_b;
        logic [15:0]        theta_b;
    } line_pair_t;

    typedef struct packed {
        logic               acc;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               sat;
    } crossing_t;

    typedef struct {
        line_pair_t pair;
        bit         known;
        crossing_t  res;
    } pair_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // rho_a, theta_a, rho_b, theta_b
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;        // cross_x, cross_y
    logic [1:0]  m_tuser;        // accepted, saturated

    crossing_t   crossings_due[$];
    logic [15:0] angle_limit = MIN_ANGLE_RESET;
    int          errors = 0;
    int          cycles = 0;
    bit          no_idle = 1'b0;

    hough_line_pair_intersect dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ---- predictor ----
    function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
        return (a * b + 64'd536870912) >> 30;
    endfunction

    function automatic longint unsigned quarter_wave(int unsigned k);
        longint unsigned z, z2, p, s;
        if (k >= 32768) return 64'd1073741824;
        z  = longint'(k) << 15;
        z2 = q30_mul(z, z);
        p  = 64'd172273;
        p  = 64'd5026995 - q30_mul(z2, p);
        p  = 64'd85569306 - q30_mul(z2, p);
        p  = 64'd693598668 - q30_mul(z2, p);
        p  = 64'd1686629713 - q30_mul(z2, p);
        s  = q30_mul(z, p);
        return (s > 64'd1073741824) ? 64'd1073741824 : s;
    endfunction

    // sin(pi*a/65536) in q30, angle wraps modulo 2*pi
    function automatic longint sine_q30(longint a);
        longint unsigned u;
        int unsigned v;
        longint mag;
        u   = a & 64'h1FFFF;
        v   = u[15:0];
        mag = (v < 32768) ? quarter_wave(v) : quarter_wave(65536 - v);
        return u[16] ? -mag : mag;
    endfunction

    // rounded quotient, ties away from zero, clipped to 32 bits
    function automatic longint round_div(longint num, longint den, inout logic sat);
        bit neg;
        longint unsigned n, d, q;
        neg = (num < 0) != (den < 0);
        n = (num < 0) ? -num : num;
        d = (den < 0) ? -den : den;
        if (d == 0) begin
            sat = 1'b1;
            return 0;
        end
        q = (2 * n + d) / (2 * d);
        if (neg) begin
            if (q > 64'd2147483648) begin
                sat = 1'b1;
                return -64'sd2147483648;
            end
            return -longint'(q);
        end
        if (q > 64'd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        return longint'(q);
    endfunction

    function automatic crossing_t predict_crossing(line_pair_t p, logic [15:0] lim);
        crossing_t r;
        longint ra, rb, ta, tb, wa, wb, diff, sa, ca, sb, cb, det;
        logic sat;
        ra = p.rho_a;
        rb = p.rho_b;
        ta = p.theta_a;
        tb = p.theta_b;
        wa = (ta < lim) ? ta + 65536 : ta;
        wb = (tb < lim) ? tb + 65536 : tb;
        diff = (wa > wb) ? wa - wb : wb - wa;
        r = '{1'b0, 32'sd0, 32'sd0, 1'b0};
        if (!(diff > lim)) return r;
        sa  = sine_q30(ta);
        ca  = sine_q30(ta + 32768);
        sb  = sine_q30(tb);
        cb  = sine_q30(tb + 32768);
        det = sine_q30(tb - ta);
        sat = 1'b0;
        r.x = 32'(round_div((ra * sb - rb * sa) * 16, det, sat));
        r.y = 32'(round_div((rb * ca - ra * cb) * 16, det, sat));
        r.acc = 1'b1;
        r.sat = sat;
        return r;
    endfunction

    // ---- sender ----
    task automatic send_pair(line_pair_t p, bit known, crossing_t res);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {p.theta_b, p.rho_b, p.theta_a, p.rho_a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        crossings_due.insert(crossings_due.size(),
                             known ? res : predict_crossing(p, angle_limit));
    endtask

    // waits out the pipe, then writes min_angle
    task automatic set_min_angle(logic [15:0] val);
        s_tvalid <= 1'b0;
        while (crossings_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        angle_limit = val;
    endtask

    function automatic line_pair_t random_pair(logic [15:0] lim);
        line_pair_t p;
        p.rho_a   = $urandom;
        p.rho_b   = $urandom;
        p.theta_a = $urandom;
        p.theta_b = $urandom;
        case ($urandom_range(0, 9))
            6: p.theta_b = p.theta_a + lim + $urandom_range(0, 2) - 1;  // acceptance edge
            7: p.theta_b = p.theta_a - $urandom_range(1, 3);            // nearly parallel
            8: begin
                p.rho_a = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                p.rho_b = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            end
            9: begin
                p.theta_a = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                p.theta_b = $urandom_range(0, 1) ? lim : lim - 16'd1;
            end
            default: ;
        endcase
        return p;
    endfunction

    pair_row_t directed_rows[13] = '{
        '{'{16'sd0, 16'd0, 16'sd0, 16'd0}, 1'b1, '{1'b0, 32'sd0, 32'sd0, 1'b0}},
        '{'{16'sd16, 16'd0, -16'sd32, 16'd32768}, 1'b1, '{1'b1, 32'sd256, -32'sd512, 1'b0}},
        '{'{16'sh7FFF, 16'd0, 16'sh8000, 16'd32768}, 1'b1,
          '{1'b1, 32'sd524272, -32'sd524288, 1'b0}},
        '{'{16'sh7FFF, 16'hFFFF, 16'sh7FFF, 16'hFFFF}, 1'b1, '{1'b0, 32'sd0, 32'sd0, 1'b0}},
        '{'{16'sd5, 16'd3000, 16'sd9, 16'd5048}, 1'b1, '{1'b0, 32'sd0, 32'sd0, 1'b0}},
        '{'{16'sd0, 16'd0, 16'sd0, 16'd2047}, 1'b1, '{1'b0, 32'sd0, 32'sd0, 1'b0}},
        '{'{16'sh8000, 16'hFFFF, 16'sh7FFF, 16'd0}, 1'b1, '{1'b0, 32'sd0, 32'sd0, 1'b0}},
        '{'{16'sd100, 16'd1000, -16'sd77, 16'd3049}, 1'b0, '{1'b0, 32'sd0, 32'sd0, 1'b0}},
        '{'{16'sh7FFF, 16'd2048, 16'sh8000, 16'd2047}, 1'b0, '{1'b0, 32'sd0, 32'sd0, 1'b0}},
        '{'{16'sh8000, 16'd16384, 16'sh7FFF, 16'd49152}, 1'b0, '{1'b0, 32'sd0, 32'sd0, 1'b0}},
        '{'{16'sh5555, 16'd100, 16'shAAAA, 16'd40000}, 1'b0, '{1'b0, 32'sd0, 32'sd0, 1'b0}},
        '{'{-16'sd1, 16'hFFFF, 16'sd1, 16'h8000}, 1'b0, '{1'b0, 32'sd0, 32'sd0, 1'b0}},
        '{'{16'sh1234, 16'h7FFF, -16'sh0F0F, 16'h0001}, 1'b0, '{1'b0, 32'sd0, 32'sd0, 1'b0}}
    };

    logic [15:0] angle_settings[7];

    initial begin
        crossing_t none;
        none = '{1'b0, 32'sd0, 32'sd0, 1'b0};
        angle_settings = '{16'd0, 16'hFFFF, 16'd0, 16'h8000, 16'd0, 16'd1, 16'd2048};
        angle_settings[2] = $urandom;
        angle_settings[4] = $urandom_range(0, 4096);
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_rows[i])
            send_pair(directed_rows[i].pair, directed_rows[i].known, directed_rows[i].res);
        foreach (angle_settings[ph]) begin
            set_min_angle(angle_settings[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // back-to-back stretch at the start of odd phases
                no_idle = (ph % 2 == 1) && (n < 80);
                send_pair(random_pair(angle_limit), 1'b0, none);
            end
        end
        s_tvalid <= 1'b0;
        while (crossings_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // ---- receiver and checker ----
    int stall_left = 0;

    always @(posedge aclk) begin
        crossing_t want;
        crossing_t got;
        if (m_tvalid && m_tready) begin
            got = '{m_tuser[0], m_tdata[31:0], m_tdata[63:32], m_tuser[1]};
            if (crossings_due.size() == 0) begin
                errors <= errors + 1;
                if (errors < 10)
                    $display("unexpected word: acc=%0b x=%0d y=%0d sat=%0b",
                             got.acc, got.x, got.y, got.sat);
            end else begin
                want = crossings_due.pop_front();
                if (got !== want) begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("mismatch: exp acc=%0b x=%0d y=%0d sat=%0b, got acc=%0b x=%0d y=%0d sat=%0b",
                                 want.acc, want.x, want.y, want.sat,
                                 got.acc, got.x, got.y, got.sat);
                end
            end
            stall_left = no_idle ? 0 : $urandom_range(0, 11);
        end
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

endmodule

// ----- sim.f -----
+incdir+design
design/hlpi_pkg.sv
design/hlpi_sine.sv
design/hlpi_div_cell.sv
design/hough_line_pair_intersect.sv
sim/tb.sv
